// ===== hw/rtl/go_back_n_sender_window_top_defines.svh =====
`ifndef GO_BACK_N_SENDER_WINDOW_TOP_DEFINES_SVH
`define GO_BACK_N_SENDER_WINDOW_TOP_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define GBN_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("gbn assertion failed");

// invariant that must hold on every cycle out of reset
`define GBN_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("gbn invariant failed");

`endif

// ===== hw/rtl/gbn_pkg.sv =====
package gbn_pkg;

   localparam int SEQ_W       = 16;
   localparam int RESULT_CAP  = 16;
   localparam int MAX_WINDOW  = 16;
   localparam int WIN_LIM_INT = (MAX_WINDOW < RESULT_CAP) ? MAX_WINDOW : RESULT_CAP;
   localparam int CNT_W       = $clog2(RESULT_CAP + 1);
   localparam int WIN_W       = 5;
   localparam int QUEUE_DEPTH = 2;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [WIN_W-1:0] WIN_LIM = WIN_LIM_INT[WIN_W-1:0];

   localparam logic [SEQ_W-1:0] TOTAL_RESET  = 16'd10;
   localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd4;

   localparam logic [CSR_ADDR_W-1:0] REG_TOTAL_FRAMES = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_WINDOW_SIZE  = 1'd1;

   localparam logic [1:0] ACT_KICK    = 2'd0;
   localparam logic [1:0] ACT_ACK     = 2'd1;
   localparam logic [1:0] ACT_TIMEOUT = 2'd2;

   localparam logic [1:0] KIND_NEW    = 2'd0;
   localparam logic [1:0] KIND_RESEND = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // one queued command: a contiguous run of sequence numbers to emit
   typedef struct packed {
      logic [SEQ_W-1:0] seq_start;
      logic [CNT_W-1:0] count;     // results to emit, at least one
      logic [CNT_W-1:0] new_cnt;   // trailing results that are new frames
      logic             status;    // single status-only result
      logic             all_done;
      logic [SEQ_W-1:0] base;
   } cmd_type;

   typedef struct packed {
      logic [SEQ_W-1:0] base_seq;
      logic [SEQ_W-1:0] next_seq;
   } win_stat_type;

endpackage

// ===== hw/rtl/gbn_queue.sv =====
module gbn_queue #(
   parameter int Depth = gbn_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  gbn_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output gbn_pkg::cmd_type pop_cmd,
   output logic             empty
);

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(Depth + 1);
   localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);
   localparam logic [CW-1:0] DepthCnt = CW'(Depth);

   gbn_pkg::cmd_type mem_ff [Depth];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign full    = (cnt_ff == DepthCnt);
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastIdx) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastIdx) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/gbn_front.sv =====
module gbn_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [gbn_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [gbn_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [1:0]                         req_action,
   input  logic [gbn_pkg::SEQ_W-1:0]          req_ack_seq,
   input  logic                               q_full,
   output logic                               q_push,
   output gbn_pkg::cmd_type                   q_cmd,
   output gbn_pkg::win_stat_type              win_stat
);

   localparam int SW = gbn_pkg::SEQ_W;
   localparam int CW = gbn_pkg::CNT_W;

   logic [SW-1:0]            total_ff;
   logic [gbn_pkg::WIN_W-1:0] window_ff;
   logic [SW-1:0]            base_ff, base_in;
   logic [SW-1:0]            next_ff, next_in;

   logic [gbn_pkg::WIN_W-1:0] eff_win;
   logic                     is_timeout;
   logic                     ack_hit;
   logic [SW:0]              win_end;
   logic [SW:0]              limit;
   logic [SW:0]              new_diff;
   logic [SW-1:0]            outstanding;
   logic [CW-1:0]            new_cnt;
   logic [CW-1:0]            replay_cnt;
   logic [CW:0]              sum;
   logic [CW-1:0]            n_res;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;
   assign win_stat   = '{base_seq: base_ff, next_seq: next_ff};

   always_comb begin
      if (window_ff == '0) begin
         eff_win = gbn_pkg::WIN_W'(1);
      end else if (window_ff > gbn_pkg::WIN_LIM) begin
         eff_win = gbn_pkg::WIN_LIM;
      end else begin
         eff_win = window_ff;
      end
   end

   always_comb begin
      is_timeout = 1'b0;
      ack_hit    = 1'b0;
      case (req_action)
         gbn_pkg::ACT_ACK: begin
            ack_hit = (req_ack_seq == base_ff) && (base_ff < next_ff);
         end
         gbn_pkg::ACT_TIMEOUT: begin
            is_timeout = 1'b1;
         end
         default: begin
            // kick, and the unused code, only refill the window
         end
      endcase

      base_in     = ack_hit ? base_ff + SW'(1) : base_ff;
      win_end     = {1'b0, base_in} + (SW + 1)'(eff_win);
      limit       = (win_end < {1'b0, total_ff}) ? win_end : {1'b0, total_ff};
      new_diff    = (limit > {1'b0, next_ff}) ? limit - {1'b0, next_ff} : '0;
      new_cnt     = new_diff[CW-1:0];
      outstanding = next_ff - base_ff;
      replay_cnt  = is_timeout ? outstanding[CW-1:0] : '0;
      sum         = {1'b0, replay_cnt} + {1'b0, new_cnt};
      n_res       = sum[CW-1:0];
      next_in     = next_ff + SW'(new_cnt);

      q_cmd.seq_start = is_timeout ? base_ff : next_ff;
      q_cmd.new_cnt   = new_cnt;
      q_cmd.status    = (n_res == '0);
      q_cmd.count     = (n_res == '0) ? CW'(1) : n_res;
      q_cmd.all_done  = (base_in >= total_ff);
      q_cmd.base      = base_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff  <= gbn_pkg::TOTAL_RESET;
         window_ff <= gbn_pkg::WINDOW_RESET;
         base_ff   <= '0;
         next_ff   <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               gbn_pkg::REG_TOTAL_FRAMES: total_ff  <= csr_wdata[SW-1:0];
               gbn_pkg::REG_WINDOW_SIZE:  window_ff <= csr_wdata[gbn_pkg::WIN_W-1:0];
               default: ;
            endcase
         end
         if (q_push) begin
            base_ff <= base_in;
            next_ff <= next_in;
         end
      end
   end

endmodule

// ===== hw/rtl/gbn_back.sv =====
module gbn_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   input  gbn_pkg::cmd_type           q_cmd,
   output logic                       q_pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [1:0]                 rsp_kind,
   output logic [gbn_pkg::SEQ_W-1:0]  rsp_frame_seq,
   output logic                       rsp_last,
   output logic                       rsp_all_done,
   output logic [gbn_pkg::SEQ_W-1:0]  rsp_window_base
);

   localparam int SW = gbn_pkg::SEQ_W;
   localparam int CW = gbn_pkg::CNT_W;

   gbn_pkg::cmd_type cmd_ff;
   logic             busy_ff, busy_in;
   logic [SW-1:0]    cur_ff;
   logic [CW-1:0]    rem_ff;
   logic             valid_ff, valid_in;
   logic [1:0]       kind_ff, kind_in;
   logic [SW-1:0]    seq_ff;
   logic             last_ff;
   logic             done_ff;
   logic [SW-1:0]    wbase_ff;
   logic             emit;

   assign emit  = busy_ff && (!valid_ff || rsp_tready);
   assign q_pop = !busy_ff && !q_empty;

   always_comb begin
      if (cmd_ff.status) begin
         kind_in = gbn_pkg::KIND_STATUS;
      end else if (rem_ff > cmd_ff.new_cnt) begin
         kind_in = gbn_pkg::KIND_RESEND;   // replayed part comes first
      end else begin
         kind_in = gbn_pkg::KIND_NEW;
      end

      if (q_pop) begin
         busy_in = 1'b1;
      end else if (emit && rem_ff == CW'(1)) begin
         busy_in = 1'b0;
      end else begin
         busy_in = busy_ff;
      end

      if (emit) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_cmd;
         cur_ff <= q_cmd.seq_start;
         rem_ff <= q_cmd.count;
      end else if (emit) begin
         cur_ff <= cur_ff + SW'(1);
         rem_ff <= rem_ff - CW'(1);
      end
      if (emit) begin
         kind_ff  <= kind_in;
         seq_ff   <= cmd_ff.status ? '0 : cur_ff;
         last_ff  <= (rem_ff == CW'(1));
         done_ff  <= cmd_ff.all_done;
         wbase_ff <= cmd_ff.base;
      end
   end

   assign rsp_tvalid      = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_frame_seq   = seq_ff;
   assign rsp_last        = last_ff;
   assign rsp_all_done    = done_ff;
   assign rsp_window_base = wbase_ff;

endmodule

// ===== hw/rtl/go_back_n_sender_window_top.sv =====
// Go-Back-N sender window. Each request item is a kick, an acknowledgement
// (req_tdata = sequence number) or a timeout, selected by req_tuser. An
// acknowledgement equal to the window base slides the window by one; a
// timeout replays base..next-1; then new sequence numbers are issued up to
// min(base + window, total_frames). Every sent or resent number is one
// response item, tlast marks the final item of a request, and a request
// that sends nothing yields one status item. The front end updates the
// window state and queues one command per request; the back end emits
// one response per cycle while it holds a command and the receiver is
// ready, and a request yields at most 16 results.
// Requests are taken back to back until the command queue (QueueDepth
// entries) fills. Registers: index 0 total_frames, index 1 window_size.
`include "go_back_n_sender_window_top_defines.svh"

module go_back_n_sender_window_top #(
   parameter int QueueDepth = gbn_pkg::QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [gbn_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [gbn_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [gbn_pkg::REQ_TDATA_W-1:0]    req_tdata,  // [15:0] ack_seq
   input  logic [1:0]                         req_tuser,  // [1:0] action
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [15:0] frame_seq, [16] all_done, [32:17] window_base, [39:33] zero
   output logic [gbn_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic [1:0]                         rsp_tuser,  // [1:0] kind
   output logic                               rsp_tlast
);

   localparam int SW = gbn_pkg::SEQ_W;

   gbn_pkg::cmd_type      push_cmd;
   gbn_pkg::cmd_type      pop_cmd;
   gbn_pkg::win_stat_type win_stat;
   logic                  q_push;
   logic                  q_full;
   logic                  q_pop;
   logic                  q_empty;
   logic [SW-1:0]         frame_seq;
   logic [SW-1:0]         window_base;
   logic                  all_done;

   gbn_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_action  (req_tuser),
      .req_ack_seq (req_tdata[SW-1:0]),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (push_cmd),
      .win_stat    (win_stat)
   );

   gbn_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty)
   );

   gbn_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_cmd           (pop_cmd),
      .q_pop           (q_pop),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_kind        (rsp_tuser),
      .rsp_frame_seq   (frame_seq),
      .rsp_last        (rsp_tlast),
      .rsp_all_done    (all_done),
      .rsp_window_base (window_base)
   );

   assign rsp_tdata = {{(gbn_pkg::RSP_TDATA_W - 2 * SW - 1){1'b0}},
                       window_base, all_done, frame_seq};

   // outstanding frames never exceed the largest window
   `GBN_ASSERT_ALWAYS(a_window_span, clock, reset,
      (win_stat.next_seq >= win_stat.base_seq) &&
      ((win_stat.next_seq - win_stat.base_seq) <= SW'(gbn_pkg::RESULT_CAP)))

   `GBN_ASSERT_NOW(a_status_alone, clock, reset,
      rsp_tvalid && (rsp_tuser == gbn_pkg::KIND_STATUS),
      rsp_tlast && (frame_seq == '0))

   `GBN_ASSERT_NOW(a_resend_in_window, clock, reset,
      rsp_tvalid && (rsp_tuser == gbn_pkg::KIND_RESEND),
      frame_seq >= window_base)

endmodule

// ===== tb/gbn_window_checker.sv =====
`timescale 1ns / 100ps

module gbn_window_checker
   import gbn_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [1:0]             req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [1:0]             rsp_tuser,
   input  logic                   rsp_tlast,
   output int                     mismatch_total,
   output int                     pending_items
);

   typedef struct packed {
      logic [6:0]       pad;
      logic [1:0]       kind;
      logic [SEQ_W-1:0] frame_seq;
      logic             last;
      logic             all_done;
      logic [SEQ_W-1:0] wbase;
   } frame_rec_t;

   frame_rec_t       frames_due[$];
   logic [SEQ_W-1:0] base_seq;
   logic [SEQ_W-1:0] next_seq;
   logic [SEQ_W-1:0] total_frames;
   logic [WIN_W-1:0] window_size;
   int               errors;

   function automatic frame_rec_t make_rec(input logic [1:0] kind, input logic [SEQ_W-1:0] seq);
      frame_rec_t rec;
      rec           = '0;
      rec.kind      = kind;
      rec.frame_seq = seq;
      return rec;
   endfunction

   // advance the window for one request item and queue the frames it emits
   task automatic issue_frames(input logic [1:0] act, input logic [SEQ_W-1:0] ack);
      frame_rec_t  burst[$];
      frame_rec_t  rec;
      int unsigned win;
      int unsigned s;
      win = window_size;
      if (win < 1) win = 1;
      if (win > WIN_LIM) win = WIN_LIM;

      if (act == ACT_ACK) begin
         if (ack == base_seq && base_seq < next_seq) base_seq = base_seq + 1'b1;
      end else if (act == ACT_TIMEOUT) begin
         for (s = base_seq; s < next_seq; s++) begin
            if (burst.size() < RESULT_CAP) burst.push_back(make_rec(KIND_RESEND, s[SEQ_W-1:0]));
         end
      end

      while ((next_seq < base_seq + win) && (next_seq < total_frames)) begin
         if (burst.size() < RESULT_CAP) burst.push_back(make_rec(KIND_NEW, next_seq));
         next_seq = next_seq + 1'b1;
      end

      if (burst.size() == 0) burst.push_back(make_rec(KIND_STATUS, '0));

      foreach (burst[k]) begin
         rec          = burst[k];
         rec.last     = (k == burst.size() - 1);
         rec.all_done = (base_seq >= total_frames);
         rec.wbase    = base_seq;
         frames_due.push_back(rec);
      end
   endtask

   task automatic flag_error(input string what, input frame_rec_t want, input frame_rec_t got);
      errors++;
      if (errors <= 10) begin
         $display("%0t ns: %s", $time, what);
         $display("   exp kind=%0d seq=%0d last=%0b done=%0b base=%0d pad=%0h",
                  want.kind, want.frame_seq, want.last, want.all_done, want.wbase, want.pad);
         $display("   got kind=%0d seq=%0d last=%0b done=%0b base=%0d pad=%0h",
                  got.kind, got.frame_seq, got.last, got.all_done, got.wbase, got.pad);
      end
   endtask

   always @(posedge clock) begin
      frame_rec_t got;
      frame_rec_t want;
      if (reset) begin
         frames_due.delete();
         base_seq     = '0;
         next_seq     = '0;
         total_frames = TOTAL_RESET;
         window_size  = WINDOW_RESET;
      end else begin
         if (csr_we) begin
            if (csr_addr == REG_TOTAL_FRAMES) total_frames = csr_wdata[SEQ_W-1:0];
            else if (csr_addr == REG_WINDOW_SIZE) window_size = csr_wdata[WIN_W-1:0];
         end

         if (rsp_tvalid && rsp_tready) begin
            got.pad       = rsp_tdata[39:33];
            got.kind      = rsp_tuser;
            got.frame_seq = rsp_tdata[15:0];
            got.last      = rsp_tlast;
            got.all_done  = rsp_tdata[16];
            got.wbase     = rsp_tdata[32:17];
            if (frames_due.size() == 0) begin
               flag_error("result item with nothing pending", '0, got);
            end else begin
               want = frames_due.pop_front();
               if (got !== want) flag_error("result item mismatch", want, got);
            end
         end

         if (req_tvalid && req_tready) issue_frames(req_tuser, req_tdata[SEQ_W-1:0]);
      end
      mismatch_total <= errors;
      pending_items  <= frames_due.size();
   end

endmodule

// ===== tb/tb_go_back_n_sender_window_top.sv =====
`timescale 1ns / 100ps

module tb_go_back_n_sender_window_top;
   import gbn_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   // spare action code, handled as a kick
   localparam logic [1:0] ACT_SPARE = 2'd3;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [1:0]             req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   rsp_tlast;

   int               mismatch_total;
   int               pending_items;
   int               cycle_cnt    = 0;
   int               stall_left   = 0;
   logic             req_gap_en   = 1'b1;
   logic             rsp_stall_en = 1'b1;
   logic [SEQ_W-1:0] seen_base    = '0;

   go_back_n_sender_window_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   gbn_window_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_total (mismatch_total),
      .pending_items  (pending_items)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver stalls at random, in bursts of random length
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (rsp_stall_en && $urandom_range(0, 99) < 15) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // latest window base reported, used to aim acks at the window
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) seen_base <= rsp_tdata[32:17];
   end

   task automatic send_item(input logic [1:0] act, input logic [SEQ_W-1:0] ack);
      if (req_gap_en && $urandom_range(0, 99) < 20) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= ack;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_items != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_regs(input logic [SEQ_W-1:0] total, input logic [CSR_DATA_W-1:0] win_word);
      csr_we    <= 1'b1;
      csr_addr  <= REG_TOTAL_FRAMES;
      csr_wdata <= total;
      @(posedge clock);
      csr_addr  <= REG_WINDOW_SIZE;
      csr_wdata <= win_word;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      int               phase;
      int               n;
      int               r;
      int               ack_run;
      logic [SEQ_W-1:0] total_val;
      logic [WIN_W-1:0] win_val;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: 10 frames, window of 4
      send_item(ACT_KICK, 16'h0000);
      send_item(ACT_ACK, 16'd0);
      send_item(ACT_ACK, 16'd0);
      send_item(ACT_ACK, 16'hFFFF);
      send_item(ACT_TIMEOUT, 16'hFFFF);
      send_item(ACT_SPARE, 16'hA5A5);
      for (n = 1; n < 4; n++) send_item(ACT_ACK, n[SEQ_W-1:0]);
      send_item(ACT_TIMEOUT, 16'h5A5A);
      for (n = 4; n < 10; n++) send_item(ACT_ACK, n[SEQ_W-1:0]);
      // all frames acked; ack equal to base with nothing outstanding
      send_item(ACT_ACK, 16'd10);
      drain();

      // oversized window clamps to the limit
      write_regs(16'd12, {11'h7FF, 5'd31});
      send_item(ACT_KICK, 16'h0000);
      drain();
      // total dropped below base and next
      write_regs(16'd0, {11'h000, 5'd4});
      send_item(ACT_TIMEOUT, 16'h0000);
      send_item(ACT_ACK, 16'd10);
      send_item(ACT_KICK, 16'h0000);
      drain();
      // largest total and full window: 15 new, then 16 replayed
      write_regs(16'hFFFF, {11'h555, 5'd16});
      send_item(ACT_KICK, 16'h0000);
      send_item(ACT_TIMEOUT, 16'h0000);
      drain();
      // zero window behaves as one
      write_regs(16'hFFFF, {11'h2AA, 5'd0});
      send_item(ACT_ACK, 16'd11);
      send_item(ACT_TIMEOUT, 16'h0000);
      drain();
      write_regs(16'd1, {11'h000, 5'd1});
      send_item(ACT_KICK, 16'h0000);
      drain();

      for (phase = 0; phase < 8; phase++) begin
         drain();
         r = $urandom_range(0, 9);
         if (r == 0) total_val = 16'd0;
         else if (r == 1) total_val = 16'hFFFF;
         else if (r == 2) total_val = 16'd1;
         else total_val = seen_base + 16'($urandom_range(1, 40));
         r = $urandom_range(0, 7);
         if (r == 0) win_val = 5'd0;
         else if (r == 1) win_val = 5'($urandom_range(17, 31));
         else win_val = 5'($urandom_range(1, 16));
         write_regs(total_val, {11'($urandom_range(0, 2047)), win_val});

         // final phase runs with no idling on either side
         req_gap_en   <= (phase < 7) && ($urandom_range(0, 3) != 0);
         rsp_stall_en <= (phase < 7) && ($urandom_range(0, 3) != 0);
         ack_run = 0;

         for (n = 0; n < 25; n++) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               // in-order acks starting from the last reported base
               send_item(ACT_ACK, seen_base + 16'(ack_run));
               ack_run++;
            end else begin
               ack_run = 0;
               if (r < 70) send_item(ACT_KICK, 16'($urandom));
               else if (r < 85) send_item(ACT_TIMEOUT, 16'($urandom));
               else if (r < 93) send_item(ACT_ACK, 16'($urandom));
               else send_item(ACT_SPARE, 16'($urandom));
            end
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatch_total == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
